@@ design/sliding_median_spike_detector_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spike detector checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_UNIT_MACROS_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_UNIT_MACROS_SVH

// check on every clock edge outside reset
`define SMSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// check on every clock edge, reset included
`define SMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/smsd_pkg.sv @@
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared constants of the sliding median spike detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smsd_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_WIDTH        = 7;
  localparam int COUNT_WIDTH      = 32;

  localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(1);

endpackage

@@ design/smsd_if.sv @@
// ----------------------------------------------------------------------------
// smsd interfaces
// Valid/ready channels for samples, results and configuration words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smsd_in_if #(
  parameter int SAMPLE_WIDTH = smsd_pkg::SAMPLE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface smsd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               judged;
  logic                               alert;
  logic [smsd_pkg::COUNT_WIDTH-1:0]   alert_total;

  modport source (output valid, judged, alert, alert_total, input ready);
  modport sink   (input valid, judged, alert, alert_total, output ready);
endinterface

interface smsd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [smsd_pkg::CFG_WIDTH-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/smsd_ring.sv @@
// ----------------------------------------------------------------------------
// smsd_ring
// Sample history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smsd_ring #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16,
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [SAMPLE_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [SAMPLE_WIDTH-1:0] rd_data
);

  logic [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/smsd_select.sv @@
// ----------------------------------------------------------------------------
// smsd_select
// Radix rank selector: finds the value of a given rank among the newest
// samples, one bit per pass, one memory word per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smsd_select #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16,
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int CW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [CW-1:0]           size,
  input  logic [CW-1:0]           rank,
  input  logic [AW-1:0]           base,
  output logic [AW-1:0]           rd_addr,
  input  logic [SAMPLE_WIDTH-1:0] rd_data,
  output logic                    done,
  output logic [SAMPLE_WIDTH-1:0] value
);

  typedef enum logic [1:0] {
    SL_IDLE,
    SL_RUN,
    SL_DRAIN,
    SL_DECIDE
  } sel_state_t;

  localparam logic [SAMPLE_WIDTH-1:0] TOP_BIT = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1);

  sel_state_t              state_r;
  logic [AW-1:0]           addr_r;
  logic [AW-1:0]           issue_r;
  logic                    dv_r;
  logic [CW-1:0]           cnt_r;
  logic [CW-1:0]           rank_r;
  logic [SAMPLE_WIDTH-1:0] pre_r;
  logic [SAMPLE_WIDTH-1:0] hi_mask_r;
  logic [SAMPLE_WIDTH-1:0] bit_mask_r;
  logic                    done_r;

  logic                    match;
  logic                    last_issue;
  logic [AW-1:0]           addr_nxt;

  assign match = dv_r && (((rd_data ^ pre_r) & hi_mask_r) == '0)
                      && ((rd_data & bit_mask_r) == '0);
  assign last_issue = (CW'(issue_r) == (size - CW'(1)));
  assign addr_nxt   = (addr_r == '0) ? AW'(WINDOW_MAX - 1) : addr_r - AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SL_IDLE;
      dv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      dv_r   <= (state_r == SL_RUN);
      done_r <= (state_r == SL_DECIDE) && bit_mask_r[0];
      unique case (state_r)
        SL_IDLE: begin
          if (start) begin
            pre_r      <= '0;
            hi_mask_r  <= '0;
            bit_mask_r <= TOP_BIT;
            rank_r     <= rank;
            addr_r     <= base;
            issue_r    <= '0;
            cnt_r      <= '0;
            state_r    <= SL_RUN;
          end
        end
        SL_RUN: begin
          if (match) begin
            cnt_r <= cnt_r + CW'(1);
          end
          addr_r  <= addr_nxt;
          issue_r <= issue_r + AW'(1);
          if (last_issue) begin
            state_r <= SL_DRAIN;
          end
        end
        SL_DRAIN: begin
          if (match) begin
            cnt_r <= cnt_r + CW'(1);
          end
          state_r <= SL_DECIDE;
        end
        SL_DECIDE: begin
          if (rank_r >= cnt_r) begin
            pre_r  <= pre_r | bit_mask_r;
            rank_r <= rank_r - cnt_r;
          end
          hi_mask_r  <= hi_mask_r | bit_mask_r;
          bit_mask_r <= bit_mask_r >> 1;
          cnt_r      <= '0;
          issue_r    <= '0;
          addr_r     <= base;
          if (bit_mask_r[0]) begin
            state_r <= SL_IDLE;
          end else begin
            state_r <= SL_RUN;
          end
        end
        default: state_r <= SL_IDLE;
      endcase
    end
  end

  assign rd_addr = addr_r;
  assign done    = done_r;
  assign value   = pre_r;

endmodule

@@ design/sliding_median_spike_detector_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_unit
// Flags samples that reach twice the median of the trailing window.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample word with a restart bit; out_ch returns one
//   result word per sample (judged, alert, saturating alert_total).
//   cfg_ch writes window_size and is always ready; the user must write it
//   only while idle, which the block itself does not enforce. in_ch is
//   ready only in idle; one sample is worked on at a time. A sample taken
//   before the window is full goes straight to the final step, which
//   registers its result word once the output is free. A tested sample
//   runs a radix rank search over the history memory: each search takes
//   SAMPLE_WIDTH bit steps, and each step reads the w newest samples, one
//   memory word per cycle, then drains the registered read port and
//   decides the bit. An odd w needs one search; an even w needs two.
//   In every case in_ch is ready again in the same cycle as the result shows.
//   Reset clears the window, the total and the output valid flag and sets
//   window_size to 1. A stalled out_ch holds its word; the next sample is
//   still taken and waits in its final step until the output is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_median_spike_detector_unit #(
  parameter int WINDOW_MAX   = smsd_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = smsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  smsd_in_if.sink     in_ch,
  smsd_out_if.source  out_ch,
  smsd_cfg_if.sink    cfg_ch
);

  import smsd_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL_LO,
    ST_SEL_HI,
    ST_FIN
  } state_t;

  state_t                   state_r;
  logic [CFG_WIDTH-1:0]     cfg_r;
  logic [AW-1:0]            pos_r;
  logic [CW-1:0]            fill_r;
  logic [COUNT_WIDTH-1:0]   count_r;
  logic [CW-1:0]            size_r;
  logic [SAMPLE_WIDTH-1:0]  sample_r;
  logic [SAMPLE_WIDTH-1:0]  lo_r;
  logic                     judged_r;
  logic                     alert_r;
  logic                     start_r;
  logic [CW-1:0]            rank_r;

  logic                     out_valid_r;
  logic                     out_judged_r;
  logic                     out_alert_r;
  logic [COUNT_WIDTH-1:0]   out_total_r;

  logic [LW-1:0]            cfg_ext;
  logic [LW-1:0]            win_ext;
  logic [CW-1:0]            win_eff;
  logic [CW-1:0]            fill_eff;
  logic                     judge_now;
  logic                     in_take;
  logic                     out_free;
  logic                     fin_go;
  logic                     start_nxt;
  logic [AW-1:0]            base;
  logic [AW-1:0]            pos_nxt;
  logic [CW-1:0]            fill_nxt;
  logic [COUNT_WIDTH-1:0]   count_nxt;
  logic [SAMPLE_WIDTH:0]    thr;
  logic                     hit;

  logic [AW-1:0]            rd_addr;
  logic [SAMPLE_WIDTH-1:0]  rd_data;
  logic                     sel_done;
  logic [SAMPLE_WIDTH-1:0]  sel_value;

  assign cfg_ext  = LW'(cfg_r);
  assign win_ext  = (cfg_ext == '0) ? LW'(1)
                  : (cfg_ext > LW'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : cfg_ext;
  assign win_eff  = CW'(win_ext);
  assign fill_eff = in_ch.restart ? '0 : fill_r;
  assign judge_now = (fill_eff >= win_eff);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fin_go       = (state_r == ST_FIN) && out_free;
  assign start_nxt    = (in_take && judge_now)
                     || ((state_r == ST_SEL_LO) && sel_done && !size_r[0]);

  assign base      = (pos_r == '0) ? AW'(WINDOW_MAX - 1) : pos_r - AW'(1);
  assign pos_nxt   = (pos_r == AW'(WINDOW_MAX - 1)) ? '0 : pos_r + AW'(1);
  assign fill_nxt  = (fill_r == CW'(WINDOW_MAX)) ? fill_r : fill_r + CW'(1);
  assign count_nxt = (alert_r && (count_r != '1)) ? count_r + COUNT_WIDTH'(1) : count_r;

  assign thr = size_r[0] ? {sel_value, 1'b0}
                         : ({1'b0, lo_r} + {1'b0, sel_value});
  assign hit = ({1'b0, sample_r} >= thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cfg_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            sample_r <= in_ch.sample;
            size_r   <= win_eff;
            judged_r <= judge_now;
            alert_r  <= 1'b0;
            if (in_ch.restart) begin
              pos_r   <= '0;
              fill_r  <= '0;
              count_r <= '0;
            end
            if (judge_now) begin
              rank_r  <= win_eff[0] ? (win_eff >> 1) : (win_eff >> 1) - CW'(1);
              state_r <= ST_SEL_LO;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_SEL_LO: begin
          if (sel_done) begin
            if (size_r[0]) begin
              alert_r <= hit;
              state_r <= ST_FIN;
            end else begin
              lo_r    <= sel_value;
              rank_r  <= size_r >> 1;
              state_r <= ST_SEL_HI;
            end
          end
        end
        ST_SEL_HI: begin
          if (sel_done) begin
            alert_r <= hit;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            pos_r        <= pos_nxt;
            fill_r       <= fill_nxt;
            count_r      <= count_nxt;
            out_judged_r <= judged_r;
            out_alert_r  <= alert_r;
            out_total_r  <= count_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  smsd_ring #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (fin_go),
    .wr_addr (pos_r),
    .wr_data (sample_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smsd_select #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .size    (size_r),
    .rank    (rank_r),
    .base    (base),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (sel_done),
    .value   (sel_value)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.judged      = out_judged_r;
  assign out_ch.alert       = out_alert_r;
  assign out_ch.alert_total = out_total_r;

endmodule

@@ design/smsd_checker.sv @@
// ----------------------------------------------------------------------------
// smsd_checker
// Port-level checks of the spike detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_median_spike_detector_unit_macros.svh"

module smsd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_judged,
  input logic                             out_alert,
  input logic [smsd_pkg::COUNT_WIDTH-1:0] out_total
);

  `SMSD_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "output word after reset")

  `SMSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "word dropped")

  `SMSD_ASSERT(a_busy_after_in, clk, rst_n, in_valid && in_ready |=> !in_ready, "busy but ready")

  `SMSD_ASSERT(a_alert_judged, clk, rst_n, out_valid && out_alert |-> out_judged, "untested alert")

  `SMSD_ASSERT(a_alert_count, clk, rst_n, out_valid && out_alert |-> |out_total, "uncounted alert")

endmodule

bind sliding_median_spike_detector_unit smsd_checker u_smsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_judged (out_ch.judged),
  .out_alert  (out_ch.alert),
  .out_total  (out_ch.alert_total)
);
